// File: src/jdrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdrc_pkg
// Shared types and constants of the joystick drive remote controller.
// ----------------------------------------------------------------------------
package jdrc_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned HOLD_W          = 16;
    localparam int unsigned ZONE_W          = 8;
    localparam int unsigned PERIOD_W        = 11;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam int unsigned FRAME_LEN       = 3;
    localparam int unsigned FILL_W          = 2;

    localparam logic [BYTE_W-1:0]   FRAME_HEAD   = 8'h55;
    localparam logic [BYTE_W-1:0]   CONFIG_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0]   AUTO_RIGHT   = 8'h21;
    localparam logic [BYTE_W-1:0]   AUTO_LEFT    = 8'h78;
    localparam logic [BYTE_W-1:0]   WHEEL_CENTRE = 8'd128;
    localparam logic [BYTE_W-1:0]   MIX_BIAS     = 8'd127;
    localparam logic [PERIOD_W-1:0] PERIOD_SLOW  = 11'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_MID   = 11'd200;
    localparam logic [PERIOD_W-1:0] PERIOD_FAST  = 11'd100;

    localparam logic [HOLD_W-1:0] MODE_HOLD_RST = 16'd2000;
    localparam logic [HOLD_W-1:0] AUTO_HOLD_RST = 16'd500;
    localparam logic [ZONE_W-1:0] DEAD_ZONE_RST = 8'd16;
    localparam logic [HOLD_W-1:0] HEARTBEAT_RST = 16'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_HOLD = 3'd0,
        REG_AUTO_HOLD = 3'd1,
        REG_X_ZONE    = 3'd2,
        REG_Y_ZONE    = 3'd3,
        REG_HEARTBEAT = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_RUN    = 1'b0,
        MODE_CONFIG = 1'b1
    } drive_mode_t;

    typedef enum logic {
        ITEM_TICK   = 1'b0,
        ITEM_SAMPLE = 1'b1
    } item_kind_t;

    // Returns the signed axis offset from centre as a wrapped byte, or zero
    // inside the dead zone.
    function automatic logic [BYTE_W-1:0] axis_offset(input logic [BYTE_W-1:0] pos,
                                                      input logic [ZONE_W-1:0] zone);
        logic [BYTE_W:0] sum_lo;
        logic [BYTE_W:0] sum_hi;
        sum_lo = {1'b0, pos} + {1'b0, zone};
        sum_hi = {1'b0, WHEEL_CENTRE} + {1'b0, zone};
        if ((sum_lo > {1'b0, WHEEL_CENTRE}) && ({1'b0, pos} < sum_hi))
        begin
            return '0;
        end
        return pos ^ WHEEL_CENTRE;
    endfunction

endpackage

// File: src/jdrc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdrc_in_if
// Input channel: ticks and controller samples with valid/ready handshake.
// ----------------------------------------------------------------------------
interface jdrc_in_if
    import jdrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [BYTE_W-1:0] joy_x;
    logic [BYTE_W-1:0] joy_y;
    logic [BYTE_W-1:0] button_byte;

    modport source (output valid, func, joy_x, joy_y, button_byte, input ready);
    modport sink   (input valid, func, joy_x, joy_y, button_byte, output ready);
endinterface

// File: src/jdrc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdrc_out_if
// Output channel: frame bytes and status levels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface jdrc_out_if
    import jdrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              byte_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
    logic              red_led;
    logic              green_led;
    logic              setup_mode;

    modport source (output valid, byte_valid, tx_byte, last, red_led, green_led,
                    setup_mode, input ready);
    modport sink   (input valid, byte_valid, tx_byte, last, red_led, green_led,
                    setup_mode, output ready);
endinterface

// File: src/joystick_drive_remote_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_drive_remote_controller
// Arcade drive mixer with dead zone, button hold timers, LED blink and
// heartbeat frame generation.
// ----------------------------------------------------------------------------
// Items enter an input register at up to one per cycle and are processed
// from it; a sample waits there until the frame buffer is free, which
// stalls the input. A tick gives no transfer on the output. A sample
// writes its results into a three-entry frame buffer and gives three
// output transfers (0x55, right, left) when a run-mode frame is due,
// otherwise one; the frame buffer drains one byte per cycle while the
// output is ready. Configuration writes take effect at the clock edge at
// which cfg_we is high and should be made only while the block is idle.
module joystick_drive_remote_controller
    import jdrc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    jdrc_in_if.sink               samples,
    jdrc_out_if.source            frames,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned CW    = COUNT_WIDTH;
    localparam int unsigned CMP_W = (CW > HOLD_W) ? CW : HOLD_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic [HOLD_W-1:0]   mode_hold_reg;
    logic [HOLD_W-1:0]   auto_hold_reg;
    logic [ZONE_W-1:0]   x_zone_reg;
    logic [ZONE_W-1:0]   y_zone_reg;
    logic [HOLD_W-1:0]   heartbeat_ms_reg;

    logic                s1_valid_reg;
    logic                s1_func_reg;
    logic [BYTE_W-1:0]   s1_x_reg;
    logic [BYTE_W-1:0]   s1_y_reg;
    logic [BYTE_W-1:0]   s1_btn_reg;

    drive_mode_t         mode_reg, mode_next;
    logic                button_z_reg, button_z_next;
    logic                button_c_reg, button_c_next;
    logic [CW-1:0]       both_hold_reg, both_hold_next;
    logic [CW-1:0]       c_hold_reg, c_hold_next;
    logic [CW-1:0]       z_hold_reg, z_hold_next;
    logic [CW-1:0]       red_count_reg, red_count_next;
    logic [CW-1:0]       green_count_reg, green_count_next;
    logic [CW-1:0]       hb_count_reg, hb_count_next;
    logic [PERIOD_W-1:0] red_period_reg, red_period_next;
    logic [PERIOD_W-1:0] green_period_reg, green_period_next;
    logic                red_level_reg, red_level_next;
    logic                green_level_reg, green_level_next;
    logic [BYTE_W-1:0]   right_wheel_reg, right_wheel_next;
    logic [BYTE_W-1:0]   left_wheel_reg, left_wheel_next;

    logic [FILL_W-1:0]   obuf_cnt_reg, obuf_cnt_next;
    logic [BYTE_W-1:0]   obuf_byte_reg [FRAME_LEN];
    logic [BYTE_W-1:0]   obuf_byte_next [FRAME_LEN];
    logic                obuf_bv_reg, obuf_bv_next;

    logic                out_xfer;
    logic                buf_free;
    logic                s1_fire;
    logic                in_xfer;
    logic                btn_z;
    logic                btn_c;
    logic                send;
    logic [BYTE_W-1:0]   dx;
    logic [BYTE_W-1:0]   dy;
    logic [BYTE_W-1:0]   mix_right;
    logic [BYTE_W-1:0]   mix_left;

    assign out_xfer = frames.valid && frames.ready;
    assign buf_free = (obuf_cnt_reg == '0) || ((obuf_cnt_reg == FILL_W'(1)) && frames.ready);
    assign s1_fire  = s1_valid_reg && ((s1_func_reg == ITEM_TICK) || buf_free);
    assign samples.ready = !s1_valid_reg || s1_fire;
    assign in_xfer  = samples.valid && samples.ready;

    assign frames.valid      = (obuf_cnt_reg != '0);
    assign frames.byte_valid = obuf_bv_reg;
    assign frames.tx_byte    = obuf_byte_reg[0];
    assign frames.last       = (obuf_cnt_reg == FILL_W'(1));
    assign frames.red_led    = red_level_reg;
    assign frames.green_led  = green_level_reg;
    assign frames.setup_mode = (mode_reg == MODE_CONFIG);

    assign btn_z     = ~s1_btn_reg[0];
    assign btn_c     = ~s1_btn_reg[1];
    assign dx        = axis_offset(s1_x_reg, x_zone_reg);
    assign dy        = axis_offset(s1_y_reg, y_zone_reg);
    assign mix_right = MIX_BIAS - dy - dx;
    assign mix_left  = MIX_BIAS - dy + dx;
    assign send      = CMP_W'(hb_count_reg) >= CMP_W'(heartbeat_ms_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_hold_reg    <= MODE_HOLD_RST;
            auto_hold_reg    <= AUTO_HOLD_RST;
            x_zone_reg       <= DEAD_ZONE_RST;
            y_zone_reg       <= DEAD_ZONE_RST;
            heartbeat_ms_reg <= HEARTBEAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE_HOLD: mode_hold_reg    <= cfg_data;
                REG_AUTO_HOLD: auto_hold_reg    <= cfg_data;
                REG_X_ZONE:    x_zone_reg       <= cfg_data[ZONE_W-1:0];
                REG_Y_ZONE:    y_zone_reg       <= cfg_data[ZONE_W-1:0];
                REG_HEARTBEAT: heartbeat_ms_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_func_reg <= samples.func;
            s1_x_reg    <= samples.joy_x;
            s1_y_reg    <= samples.joy_y;
            s1_btn_reg  <= samples.button_byte;
        end
    end

    always_comb
    begin
        mode_next         = mode_reg;
        button_z_next     = button_z_reg;
        button_c_next     = button_c_reg;
        both_hold_next    = both_hold_reg;
        c_hold_next       = c_hold_reg;
        z_hold_next       = z_hold_reg;
        red_count_next    = red_count_reg;
        green_count_next  = green_count_reg;
        hb_count_next     = hb_count_reg;
        red_period_next   = red_period_reg;
        green_period_next = green_period_reg;
        red_level_next    = red_level_reg;
        green_level_next  = green_level_reg;
        right_wheel_next  = right_wheel_reg;
        left_wheel_next   = left_wheel_reg;
        obuf_cnt_next     = obuf_cnt_reg;
        obuf_bv_next      = obuf_bv_reg;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            obuf_byte_next[i] = obuf_byte_reg[i];
        end

        if (out_xfer)
        begin
            obuf_cnt_next = obuf_cnt_reg - FILL_W'(1);
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                obuf_byte_next[i] = obuf_byte_reg[i+1];
            end
        end

        if (s1_fire && (s1_func_reg == ITEM_TICK))
        begin
            hb_count_next    = (hb_count_reg == CNT_MAX) ? CNT_MAX : hb_count_reg + CW'(1);
            red_count_next   = (red_count_reg == CNT_MAX) ? CNT_MAX : red_count_reg + CW'(1);
            green_count_next = (green_count_reg == CNT_MAX) ? CNT_MAX
                                                            : green_count_reg + CW'(1);
            if (button_z_reg && button_c_reg)
            begin
                both_hold_next    = (both_hold_reg == CNT_MAX) ? CNT_MAX
                                                               : both_hold_reg + CW'(1);
                red_period_next   = PERIOD_FAST;
                green_period_next = PERIOD_FAST;
            end
            else
            begin
                both_hold_next = '0;
                if (!button_c_reg)
                begin
                    c_hold_next = '0;
                end
                else if (c_hold_reg != CNT_MAX)
                begin
                    c_hold_next = c_hold_reg + CW'(1);
                end
                if (!button_z_reg)
                begin
                    z_hold_next = '0;
                end
                else if (z_hold_reg != CNT_MAX)
                begin
                    z_hold_next = z_hold_reg + CW'(1);
                end
            end
        end
        else if (s1_fire)
        begin
            button_z_next = btn_z;
            button_c_next = btn_c;

            if (z_hold_reg != '0)
            begin
                z_hold_next      = '0;
                right_wheel_next = WHEEL_CENTRE;
                left_wheel_next  = WHEEL_CENTRE;
            end
            else if (mode_reg == MODE_RUN)
            begin
                if (CMP_W'(both_hold_reg) > CMP_W'(mode_hold_reg))
                begin
                    both_hold_next    = '0;
                    red_period_next   = PERIOD_MID;
                    green_period_next = PERIOD_MID;
                    mode_next         = MODE_CONFIG;
                end
                else if (both_hold_reg != '0)
                begin
                    red_period_next   = PERIOD_FAST;
                    green_period_next = PERIOD_MID;
                end
                else
                begin
                    red_period_next   = PERIOD_SLOW;
                    green_period_next = PERIOD_SLOW;
                    if (CMP_W'(c_hold_reg) > CMP_W'(auto_hold_reg))
                    begin
                        c_hold_next      = '0;
                        right_wheel_next = AUTO_RIGHT;
                        left_wheel_next  = AUTO_LEFT;
                        red_level_next   = 1'b1;
                        green_level_next = 1'b1;
                    end
                    else
                    begin
                        right_wheel_next = mix_right;
                        left_wheel_next  = mix_left;
                    end
                end
            end
            else
            begin
                if (CMP_W'(both_hold_reg) > CMP_W'(mode_hold_reg))
                begin
                    both_hold_next    = '0;
                    red_period_next   = PERIOD_SLOW;
                    green_period_next = PERIOD_SLOW;
                    mode_next         = MODE_RUN;
                end
                else if (both_hold_reg != '0)
                begin
                    red_period_next   = PERIOD_MID;
                    green_period_next = PERIOD_MID;
                end
            end

            if (CMP_W'(red_count_reg) > CMP_W'(red_period_next))
            begin
                red_count_next = '0;
                red_level_next = ~red_level_next;
            end
            if (CMP_W'(green_count_reg) > CMP_W'(green_period_next))
            begin
                green_count_next = '0;
                green_level_next = ~green_level_next;
            end

            if (send)
            begin
                hb_count_next = '0;
                obuf_bv_next  = 1'b1;
                if (mode_next == MODE_RUN)
                begin
                    obuf_cnt_next     = FILL_W'(FRAME_LEN);
                    obuf_byte_next[0] = FRAME_HEAD;
                    obuf_byte_next[1] = right_wheel_next;
                    obuf_byte_next[2] = left_wheel_next;
                end
                else
                begin
                    obuf_cnt_next     = FILL_W'(1);
                    obuf_byte_next[0] = CONFIG_BYTE;
                end
            end
            else
            begin
                obuf_bv_next      = 1'b0;
                obuf_cnt_next     = FILL_W'(1);
                obuf_byte_next[0] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_RUN;
            button_z_reg     <= 1'b0;
            button_c_reg     <= 1'b0;
            both_hold_reg    <= '0;
            c_hold_reg       <= '0;
            z_hold_reg       <= '0;
            red_count_reg    <= '0;
            green_count_reg  <= '0;
            hb_count_reg     <= '0;
            red_period_reg   <= PERIOD_SLOW;
            green_period_reg <= PERIOD_SLOW;
            red_level_reg    <= 1'b0;
            green_level_reg  <= 1'b0;
            right_wheel_reg  <= WHEEL_CENTRE;
            left_wheel_reg   <= WHEEL_CENTRE;
            obuf_cnt_reg     <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            button_z_reg     <= button_z_next;
            button_c_reg     <= button_c_next;
            both_hold_reg    <= both_hold_next;
            c_hold_reg       <= c_hold_next;
            z_hold_reg       <= z_hold_next;
            red_count_reg    <= red_count_next;
            green_count_reg  <= green_count_next;
            hb_count_reg     <= hb_count_next;
            red_period_reg   <= red_period_next;
            green_period_reg <= green_period_next;
            red_level_reg    <= red_level_next;
            green_level_reg  <= green_level_next;
            right_wheel_reg  <= right_wheel_next;
            left_wheel_reg   <= left_wheel_next;
            obuf_cnt_reg     <= obuf_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obuf_bv_reg <= obuf_bv_next;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            obuf_byte_reg[i] <= obuf_byte_next[i];
        end
    end

endmodule

// File: src/jdrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdrc_checker
// Port-level checks of the result stream of the remote controller.
// ----------------------------------------------------------------------------
module jdrc_checker
    import jdrc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              f_valid,
    input logic              f_ready,
    input logic              f_byte_valid,
    input logic [BYTE_W-1:0] f_tx_byte,
    input logic              f_last,
    input logic              f_setup_mode
);

    // A stalled result keeps its byte.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_tx_byte) && $stable(f_last))
        else $error("result changed while stalled");

    // A sample without a frame gives a single empty result.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_byte_valid |-> f_last && (f_tx_byte == '0))
        else $error("empty result is not a single zero byte");

    // In config mode a frame is a single zero byte.
    a_config: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && f_byte_valid && f_setup_mode |-> f_last && (f_tx_byte == CONFIG_BYTE))
        else $error("config frame is not a single zero byte");

    // The bytes of one frame follow each other without a gap.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && f_ready && !f_last |=> f_valid && f_byte_valid)
        else $error("frame interrupted");

endmodule

bind joystick_drive_remote_controller jdrc_checker u_jdrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .f_valid      (frames.valid),
    .f_ready      (frames.ready),
    .f_byte_valid (frames.byte_valid),
    .f_tx_byte    (frames.tx_byte),
    .f_last       (frames.last),
    .f_setup_mode (frames.setup_mode)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the joystick drive remote controller. A queue of ticks and
// controller samples feeds a driver with random idle bursts. A monitor with
// random stalls checks each output transfer against frames predicted by a
// behavioral model of the hold timers, mode switch, drive mixer, LED blink
// and heartbeat. The run uses directed sequences, randomized hold sequences,
// a long tick run for LED blinking, and several register settings.
// ----------------------------------------------------------------------------
module tb;
    import jdrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CW             = COUNT_WIDTH_DEF;

    localparam logic [BYTE_W-1:0] BTN_NONE = 8'hFF;
    localparam logic [BYTE_W-1:0] BTN_Z    = 8'hFE;
    localparam logic [BYTE_W-1:0] BTN_C    = 8'hFD;
    localparam logic [BYTE_W-1:0] BTN_BOTH = 8'hFC;

    typedef struct packed {
        item_kind_t        func;
        logic [BYTE_W-1:0] joy_x;
        logic [BYTE_W-1:0] joy_y;
        logic [BYTE_W-1:0] button_byte;
        logic              calm;
    } drive_item_t;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
        logic              red_led;
        logic              green_led;
        logic              setup_mode;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic feed_valid = 1'b0;
    drive_item_t feed_item = '0;
    logic sink_ready = 1'b0;
    logic no_idle = 1'b0;

    int feed_gap = 0;
    int sink_stall = 0;
    int idle_cycles = 0;
    int mismatch_count = 0;

    drive_item_t item_q[$];
    frame_t expected_frames[$];
    frame_t want;

    // Register copies
    logic [HOLD_W-1:0] mode_hold_lim;
    logic [HOLD_W-1:0] auto_hold_lim;
    logic [ZONE_W-1:0] x_zone;
    logic [ZONE_W-1:0] y_zone;
    logic [HOLD_W-1:0] beat_lim;

    // Controller state
    drive_mode_t ctl_mode = MODE_RUN;
    logic btn_z = 1'b0;
    logic btn_c = 1'b0;
    logic [CW-1:0] both_hold = '0;
    logic [CW-1:0] c_hold = '0;
    logic [CW-1:0] z_hold = '0;
    logic [CW-1:0] red_cnt = '0;
    logic [CW-1:0] green_cnt = '0;
    logic [CW-1:0] beat_cnt = '0;
    logic [PERIOD_W-1:0] red_per = PERIOD_SLOW;
    logic [PERIOD_W-1:0] green_per = PERIOD_SLOW;
    logic red_lvl = 1'b0;
    logic green_lvl = 1'b0;
    logic [BYTE_W-1:0] right_wheel = WHEEL_CENTRE;
    logic [BYTE_W-1:0] left_wheel = WHEEL_CENTRE;

    jdrc_in_if in_if ();
    jdrc_out_if out_if ();

    assign in_if.valid       = feed_valid;
    assign in_if.func        = feed_item.func;
    assign in_if.joy_x       = feed_item.joy_x;
    assign in_if.joy_y       = feed_item.joy_y;
    assign in_if.button_byte = feed_item.button_byte;
    assign out_if.ready      = sink_ready;

    joystick_drive_remote_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (in_if),
        .frames    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [CW-1:0] sat_up(input logic [CW-1:0] v);
        return (&v) ? v : v + CW'(1);
    endfunction

    function automatic int centre_offset(input logic [BYTE_W-1:0] pos,
                                         input logic [ZONE_W-1:0] zone);
        int p;
        int d;
        p = pos;
        d = zone;
        if (p > int'(WHEEL_CENTRE) - d && p < int'(WHEEL_CENTRE) + d)
        begin
            return 0;
        end
        return p - int'(WHEEL_CENTRE);
    endfunction

    task automatic advance_controller(input drive_item_t it);
        int dx;
        int dy;
        int n;
        logic send;
        logic [BYTE_W-1:0] bytes [FRAME_LEN];
        frame_t f;
        if (it.func == ITEM_TICK)
        begin
            beat_cnt = sat_up(beat_cnt);
            red_cnt = sat_up(red_cnt);
            green_cnt = sat_up(green_cnt);
            if (btn_z && btn_c)
            begin
                both_hold = sat_up(both_hold);
                red_per = PERIOD_FAST;
                green_per = PERIOD_FAST;
            end
            else
            begin
                both_hold = '0;
                c_hold = btn_c ? sat_up(c_hold) : '0;
                z_hold = btn_z ? sat_up(z_hold) : '0;
            end
            return;
        end
        btn_z = ~it.button_byte[0];
        btn_c = ~it.button_byte[1];
        if (z_hold != 0)
        begin
            z_hold = '0;
            right_wheel = WHEEL_CENTRE;
            left_wheel = WHEEL_CENTRE;
        end
        else if (ctl_mode == MODE_RUN)
        begin
            if (both_hold > mode_hold_lim)
            begin
                both_hold = '0;
                red_per = PERIOD_MID;
                green_per = PERIOD_MID;
                ctl_mode = MODE_CONFIG;
            end
            else if (both_hold != 0)
            begin
                red_per = PERIOD_FAST;
                green_per = PERIOD_MID;
            end
            else
            begin
                red_per = PERIOD_SLOW;
                green_per = PERIOD_SLOW;
                if (c_hold > auto_hold_lim)
                begin
                    c_hold = '0;
                    right_wheel = AUTO_RIGHT;
                    left_wheel = AUTO_LEFT;
                    red_lvl = 1'b1;
                    green_lvl = 1'b1;
                end
                else
                begin
                    dx = centre_offset(it.joy_x, x_zone);
                    dy = centre_offset(it.joy_y, y_zone);
                    right_wheel = 8'(int'(MIX_BIAS) - dy - dx);
                    left_wheel = 8'(int'(MIX_BIAS) - dy + dx);
                end
            end
        end
        else
        begin
            if (both_hold > mode_hold_lim)
            begin
                both_hold = '0;
                red_per = PERIOD_SLOW;
                green_per = PERIOD_SLOW;
                ctl_mode = MODE_RUN;
            end
            else if (both_hold != 0)
            begin
                red_per = PERIOD_MID;
                green_per = PERIOD_MID;
            end
        end
        send = (beat_cnt >= beat_lim);
        n = 0;
        if (send)
        begin
            beat_cnt = '0;
            if (ctl_mode == MODE_RUN)
            begin
                bytes[0] = FRAME_HEAD;
                bytes[1] = right_wheel;
                bytes[2] = left_wheel;
                n = FRAME_LEN;
            end
            else
            begin
                bytes[0] = CONFIG_BYTE;
                n = 1;
            end
        end
        if (red_cnt > red_per)
        begin
            red_cnt = '0;
            red_lvl = ~red_lvl;
        end
        if (green_cnt > green_per)
        begin
            green_cnt = '0;
            green_lvl = ~green_lvl;
        end
        f.red_led = red_lvl;
        f.green_led = green_lvl;
        f.setup_mode = ctl_mode;
        if (n == 0)
        begin
            f.byte_valid = 1'b0;
            f.tx_byte = '0;
            f.last = 1'b1;
            expected_frames.push_back(f);
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                f.byte_valid = 1'b1;
                f.tx_byte = bytes[k];
                f.last = (k == n - 1);
                expected_frames.push_back(f);
            end
        end
    endtask

    // Driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            feed_valid <= 1'b0;
            feed_gap <= 0;
        end
        else
        begin
            if (feed_valid && in_if.ready)
            begin
                advance_controller(feed_item);
            end
            if (!feed_valid || in_if.ready)
            begin
                if (feed_gap != 0)
                begin
                    feed_gap <= feed_gap - 1;
                    feed_valid <= 1'b0;
                end
                else if (item_q.size() == 0)
                begin
                    feed_valid <= 1'b0;
                end
                else if (!no_idle && !item_q[0].calm && $urandom_range(0, 7) == 0)
                begin
                    feed_gap <= $urandom_range(0, 15);
                    feed_valid <= 1'b0;
                end
                else
                begin
                    feed_item <= item_q.pop_front();
                    feed_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (out_if.valid && sink_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Unexpected transfer: ",
                                 "valid=%0b byte=%02h last=%0b red=%0b green=%0b cfg=%0b",
                                 out_if.byte_valid, out_if.tx_byte, out_if.last,
                                 out_if.red_led, out_if.green_led, out_if.setup_mode);
                    end
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (want.byte_valid !== out_if.byte_valid || want.tx_byte !== out_if.tx_byte
                        || want.last !== out_if.last || want.red_led !== out_if.red_led
                        || want.green_led !== out_if.green_led
                        || want.setup_mode !== out_if.setup_mode)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("Mismatch: expected ",
                                     "valid=%0b byte=%02h last=%0b red=%0b green=%0b cfg=%0b",
                                     want.byte_valid, want.tx_byte, want.last,
                                     want.red_led, want.green_led, want.setup_mode);
                            $display("          actual   ",
                                     "valid=%0b byte=%02h last=%0b red=%0b green=%0b cfg=%0b",
                                     out_if.byte_valid, out_if.tx_byte, out_if.last,
                                     out_if.red_led, out_if.green_led, out_if.setup_mode);
                        end
                    end
                end
            end
            if (sink_stall != 0)
            begin
                sink_stall <= sink_stall - 1;
                sink_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                sink_stall <= $urandom_range(0, 15);
                sink_ready <= 1'b0;
            end
            else
            begin
                sink_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (feed_valid && in_if.ready) || (out_if.valid && sink_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(input item_kind_t kind, input logic [BYTE_W-1:0] x,
                             input logic [BYTE_W-1:0] y, input logic [BYTE_W-1:0] b,
                             input logic calm);
        drive_item_t it;
        it.func = kind;
        it.joy_x = x;
        it.joy_y = y;
        it.button_byte = b;
        it.calm = calm;
        item_q.push_back(it);
    endtask

    task automatic push_ticks(input int count, input logic calm);
        for (int k = 0; k < count; k++)
        begin
            push_item(ITEM_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), calm);
        end
    endtask

    function automatic logic [BYTE_W-1:0] with_noise(input logic [BYTE_W-1:0] pattern);
        return {6'($urandom_range(0, 63)), pattern[1:0]};
    endfunction

    // Joystick positions cluster around the dead zone edges half of the time.
    function automatic logic [BYTE_W-1:0] pick_axis(input logic [ZONE_W-1:0] zone);
        if ($urandom_range(0, 1) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 1) == 0)
        begin
            return WHEEL_CENTRE - zone + 8'($urandom_range(0, 2)) - 8'd1;
        end
        return WHEEL_CENTRE + zone + 8'($urandom_range(0, 2)) - 8'd1;
    endfunction

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_MODE_HOLD: mode_hold_lim = value;
            REG_AUTO_HOLD: auto_hold_lim = value;
            REG_X_ZONE:    x_zone = value[ZONE_W-1:0];
            REG_Y_ZONE:    y_zone = value[ZONE_W-1:0];
            REG_HEARTBEAT: beat_lim = value;
            default: ;
        endcase
    endtask

    task automatic program_limits(input logic [HOLD_W-1:0] mode_hold,
                                  input logic [HOLD_W-1:0] auto_hold,
                                  input logic [ZONE_W-1:0] xz, input logic [ZONE_W-1:0] yz,
                                  input logic [HOLD_W-1:0] beat);
        write_limit(REG_MODE_HOLD, mode_hold);
        write_limit(REG_AUTO_HOLD, auto_hold);
        write_limit(REG_X_ZONE, {8'($urandom_range(0, 255)), xz});
        write_limit(REG_Y_ZONE, {8'($urandom_range(0, 255)), yz});
        write_limit(REG_HEARTBEAT, beat);
        write_limit(CFG_IDX_W'(REG_HEARTBEAT) + 3'($urandom_range(1, 3)),
                    16'($urandom_range(0, 65535)));
        @(posedge clk);
        cfg_we <= 1'b0;
        #1;
    endtask

    task automatic wait_idle();
        while (item_q.size() != 0 || feed_valid || expected_frames.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        #1;
    endtask

    // Mostly press-hold-release sequences with random content, the rest noise.
    task automatic queue_drive_mix(input int count);
        int added;
        int hold;
        logic [BYTE_W-1:0] press;
        added = 0;
        while (added < count)
        begin
            case ($urandom_range(0, 4))
                0: press = BTN_NONE;
                1: press = BTN_Z;
                2: press = BTN_C;
                3: press = BTN_BOTH;
                default: press = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 9) < 7)
            begin
                hold = $urandom_range(0, 8);
                push_item(ITEM_SAMPLE, pick_axis(x_zone), pick_axis(y_zone),
                          with_noise(press), 1'b0);
                push_ticks(hold, 1'b0);
                push_item(ITEM_SAMPLE, pick_axis(x_zone), pick_axis(y_zone),
                          with_noise($urandom_range(0, 1) ? press : BTN_NONE), 1'b0);
                added += hold + 2;
            end
            else
            begin
                push_item(item_kind_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
                added++;
            end
        end
    endtask

    initial
    begin
        mode_hold_lim = MODE_HOLD_RST;
        auto_hold_lim = AUTO_HOLD_RST;
        x_zone = DEAD_ZONE_RST;
        y_zone = DEAD_ZONE_RST;
        beat_lim = HEARTBEAT_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        #1;

        // Reset settings: a frame is due after five ticks, offsets on the zone edges.
        push_ticks(5, 1'b0);
        push_item(ITEM_SAMPLE, 8'd144, 8'd112, BTN_NONE, 1'b0);
        wait_idle();

        program_limits(16'd1, 16'd1, 8'd0, 8'd128, 16'd0);
        push_item(ITEM_SAMPLE, 8'd0, 8'd0, BTN_NONE, 1'b0);
        push_item(ITEM_SAMPLE, 8'd255, 8'd255, BTN_NONE, 1'b0);
        push_item(ITEM_SAMPLE, 8'd128, 8'd127, BTN_NONE, 1'b0);
        // Emergency stop while Z is held.
        push_item(ITEM_SAMPLE, 8'd20, 8'd200, BTN_Z, 1'b0);
        push_ticks(1, 1'b0);
        push_item(ITEM_SAMPLE, 8'd20, 8'd200, BTN_NONE, 1'b0);
        // Long C hold sends the auto command.
        push_item(ITEM_SAMPLE, 8'd60, 8'd60, BTN_C, 1'b0);
        push_ticks(2, 1'b0);
        push_item(ITEM_SAMPLE, 8'd60, 8'd60, BTN_NONE, 1'b0);
        // Long hold of both buttons enters and then leaves config mode.
        push_item(ITEM_SAMPLE, 8'd90, 8'd30, BTN_BOTH, 1'b0);
        push_ticks(2, 1'b0);
        push_item(ITEM_SAMPLE, 8'd90, 8'd30, BTN_BOTH, 1'b0);
        push_ticks(2, 1'b0);
        push_item(ITEM_SAMPLE, 8'd90, 8'd30, BTN_NONE, 1'b0);
        wait_idle();

        program_limits(16'd0, 16'd0, 8'd128, 8'd0, 16'hFFFF);
        queue_drive_mix(48);
        wait_idle();

        program_limits(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                       8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)),
                       16'($urandom_range(0, 8)));
        queue_drive_mix(48);
        wait_idle();

        // A long tick run with both buttons held makes the red LED toggle at the fast period.
        program_limits(16'hFFFF, 16'hFFFF, 8'd16, 8'd16, 16'd3);
        push_item(ITEM_SAMPLE, 8'd128, 8'd128, BTN_BOTH, 1'b0);
        push_ticks(102, 1'b1);
        push_item(ITEM_SAMPLE, 8'd128, 8'd128, BTN_NONE, 1'b0);
        wait_idle();

        program_limits(16'hFFFF, 16'hFFFF, 8'($urandom_range(0, 128)),
                       8'($urandom_range(0, 128)), 16'd1);
        queue_drive_mix(48);
        wait_idle();

        no_idle = 1'b1;
        program_limits(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                       8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)),
                       16'($urandom_range(0, 8)));
        queue_drive_mix(48);
        wait_idle();

        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
